FILE: src/dss_pkg.sv
// Package: shared constants, types and the sine table function for the drum step sequencer.
`default_nettype none
package dss_pkg;
    localparam int STEP_COUNT_DEF      = 16;
    localparam int VOICE_COUNT_DEF     = 3;
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int PATTERN_STEPS       = 16;

    localparam logic [15:0] ENV_FULL  = 16'hFFFF;
    localparam logic [15:0] ENV_FLOOR = 16'd65;
    localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

    localparam logic [2:0] REG_PATTERN = 3'd0;
    localparam logic [2:0] REG_RUN     = 3'd1;
    localparam logic [2:0] REG_LEVEL   = 3'd2;
    localparam logic [2:0] REG_SPS     = 3'd3;
    localparam logic [2:0] REG_KDECAY  = 3'd4;
    localparam logic [2:0] REG_SDECAY  = 3'd5;
    localparam logic [2:0] REG_HDECAY  = 3'd6;
    localparam logic [2:0] REG_PPH     = 3'd7;

    typedef struct packed {
        logic [47:0] pattern_bits;
        logic        run_enable;
        logic [15:0] output_level;
        logic [15:0] samples_per_step;
        logic [15:0] kick_decay;
        logic [15:0] snare_decay;
        logic [15:0] hat_decay;
        logic [19:0] phase_per_hertz;
    } cfg_t;

    // Multiplier operation handed from the sequencer to the shared unit.
    typedef struct packed {
        logic signed [35:0] a;
        logic signed [35:0] b;
        logic [5:0]         shift;
    } mul_req_t;

    // Floor division by 2^n of a signed value.
    function automatic logic signed [71:0] asr72(input logic signed [71:0] v,
                                                 input logic [5:0] n);
        asr72 = v >>> n;
    endfunction

    // Truncating division by 2^16 (toward zero), as C integer division.
    function automatic longint tdiv16(input longint v);
        longint r;
        r = (v < 0) ? -((-v) >>> 16) : (v >>> 16);
        tdiv16 = r;
    endfunction

    // Quarter-wave sine value, evaluated at elaboration into a constant table.
    function automatic logic [14:0] quarter_sine(input int q, input int bits);
        longint t;
        longint t2;
        longint p;
        longint s;
        t  = (longint'(q) <<< 16) >>> (bits - 2);
        t2 = tdiv16(t * t);
        p  = -307;
        p  = 5223 + tdiv16(p * t2);
        p  = -42334 + tdiv16(p * t2);
        p  = 102944 + tdiv16(p * t2);
        s  = tdiv16(p * t);
        s  = (s < 0) ? -((-s) >>> 1) : (s >>> 1);
        if (s < 0) s = 0;
        if (s > 32767) s = 32767;
        quarter_sine = 15'(s);
    endfunction
endpackage
`default_nettype wire

FILE: src/dss_if.sv
// Interfaces: valid/ready stream and configuration write channel.
`default_nettype none
interface dss_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dss_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic [3:0]         current_step;
    logic               step_began;
    modport source (output valid, output sample, output current_step, output step_began,
                    input ready);
    modport sink   (input valid, input sample, input current_step, input step_began,
                    output ready);
endinterface

interface dss_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [47:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

FILE: src/dss_sine_rom.sv
// Sine table: quarter-wave constant table with registered read.
`default_nettype none
module dss_sine_rom #(
    parameter int SINE_TABLE_BITS = dss_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic [31:0]         phase,
    output logic signed [15:0]       sine
);
    localparam int QBITS   = SINE_TABLE_BITS - 2;
    localparam int QDEPTH  = 1 << QBITS;

    logic [14:0] qtab [0:QDEPTH];
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [QBITS-1:0] q;
    logic [1:0]  quad;
    logic [QBITS:0] addr;
    logic signed [15:0] sine_next;
    logic signed [15:0] sine_reg;

    always_comb
    begin
        for (int i = 0; i <= QDEPTH; i++)
        begin
            qtab[i] = dss_pkg::quarter_sine(i, SINE_TABLE_BITS);
        end
    end

    assign idx  = phase[31 -: SINE_TABLE_BITS];
    assign q    = idx[QBITS-1:0];
    assign quad = idx[SINE_TABLE_BITS-1 -: 2];
    assign addr = quad[0] ? ((QBITS+1)'(QDEPTH) - {1'b0, q}) : {1'b0, q};

    always_comb
    begin
        sine_next = quad[1] ? -$signed({1'b0, qtab[addr]}) : $signed({1'b0, qtab[addr]});
    end

    always_ff @(posedge clk)
    begin
        sine_reg <= sine_next;
    end

    assign sine = sine_reg;
endmodule
`default_nettype wire

FILE: src/dss_mul_unit.sv
// Shared multiplier: one registered signed multiply with arithmetic right shift.
`default_nettype none
module dss_mul_unit (
    input  wire logic               clk,
    input  wire dss_pkg::mul_req_t  req,
    output logic signed [47:0]      product
);
    logic signed [71:0] full;
    logic signed [47:0] product_reg;

    assign full = dss_pkg::asr72(72'(req.a) * 72'(req.b), req.shift);

    always_ff @(posedge clk)
    begin
        product_reg <= full[47:0];
    end

    assign product = product_reg;
endmodule
`default_nettype wire

FILE: src/drum_step_sequencer_synth.sv
// Top level: three-voice drum synthesizer with a 16-step pattern sequencer.
//
// One accepted tick transaction produces one sample transaction. A tick of 1
// runs a fixed sequence of states through one shared 36x36 multiplier and
// a registered sine table (five for the kick, four for the snare, three for
// the hat, then the mix scale and handoff); a tick of 0 sends a silent
// sample straight to the output register.
// tick_in.ready is low while a sample is in work. The finished sample waits
// in an output register; the next tick is accepted as soon as that register
// is free, so a stalled result adds its stall cycles to the next sample.
// Configuration writes are always accepted and apply at once; write only
// while no sample is in work.
`default_nettype none
module drum_step_sequencer_synth #(
    parameter int STEP_COUNT      = dss_pkg::STEP_COUNT_DEF,
    parameter int SINE_TABLE_BITS = dss_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    dss_stream_if.sink     tick_in,
    dss_out_if.source      result,
    dss_cfg_if.sink        cfg
);
    localparam int SW = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;

    // Sequencer states
    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_KPH    = 5'd1;  // kick phase increment multiply
    localparam logic [4:0] ST_KSIN   = 5'd2;  // wait sine
    localparam logic [4:0] ST_KM1    = 5'd3;  // env*sin
    localparam logic [4:0] ST_KM2    = 5'd4;  // *58982
    localparam logic [4:0] ST_KDEC   = 5'd5;
    localparam logic [4:0] ST_SSIN   = 5'd6;
    localparam logic [4:0] ST_SM1    = 5'd7;  // sin*19661
    localparam logic [4:0] ST_SM2    = 5'd8;  // env*inner
    localparam logic [4:0] ST_SDEC   = 5'd9;
    localparam logic [4:0] ST_HM1    = 5'd10; // env*diff
    localparam logic [4:0] ST_HM2    = 5'd11; // *19661
    localparam logic [4:0] ST_HDEC   = 5'd12;
    localparam logic [4:0] ST_MIX    = 5'd13; // mix*level
    localparam logic [4:0] ST_DONE   = 5'd14;

    dss_pkg::cfg_t cfg_reg;

    logic [4:0]  state_reg, state_next;
    logic [SW-1:0] step_reg;
    logic [15:0] count_reg;
    logic [15:0] kenv_reg, senv_reg, henv_reg;
    logic [31:0] kph_reg, sph_reg;
    logic signed [15:0] hlp_reg;
    logic [31:0] lfsr_reg;
    logic signed [15:0] na_reg, nb_reg;
    logic signed [31:0] mix_reg;
    logic signed [31:0] inner_reg;
    logic        began_reg;
    logic        kact_reg, sact_reg, hact_reg;

    logic        out_valid_reg;
    logic signed [15:0] out_sample_reg;
    logic [3:0]  out_step_reg;
    logic        out_began_reg;

    dss_pkg::mul_req_t req;
    logic signed [47:0] prod;
    logic [31:0] rom_phase;
    logic signed [15:0] sine;

    dss_mul_unit u_mul (.clk(clk), .req(req), .product(prod));
    dss_sine_rom #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_rom
        (.clk(clk), .phase(rom_phase), .sine(sine));

    assign cfg.ready     = 1'b1;
    assign tick_in.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign result.valid        = out_valid_reg;
    assign result.sample       = out_sample_reg;
    assign result.current_step = out_step_reg;
    assign result.step_began   = out_began_reg;

    // Galois LFSR step
    function automatic logic [31:0] lfsr_step(input logic [31:0] v);
        lfsr_step = v[0] ? ((v >> 1) ^ dss_pkg::LFSR_MASK) : (v >> 1);
    endfunction

    logic accept;
    logic [31:0] l1, l2;
    logic [15:0] len;
    logic [15:0] cnt_inc;
    logic        trig_k, trig_s, trig_h;
    logic signed [16:0] hdiff_pre;
    logic signed [15:0] hlp_new;
    logic signed [16:0] hdiff;
    logic signed [47:0] sat_src;
    logic [31:0] kph_new, sph_new;

    assign accept  = tick_in.valid && tick_in.ready;
    assign l1      = lfsr_step(lfsr_reg);
    assign l2      = lfsr_step(l1);
    assign len     = (cfg_reg.samples_per_step == 16'd0) ? 16'd1 : cfg_reg.samples_per_step;
    assign cnt_inc = count_reg + 16'd1;
    // Steps beyond the pattern trigger nothing
    assign trig_k = (int'(step_reg) < dss_pkg::PATTERN_STEPS) && (count_reg == 16'd0)
                    && cfg_reg.pattern_bits[6'(step_reg) & 6'hF];
    assign trig_s = (int'(step_reg) < dss_pkg::PATTERN_STEPS) && (count_reg == 16'd0)
                    && cfg_reg.pattern_bits[6'd16 + (6'(step_reg) & 6'hF)];
    assign trig_h = (int'(step_reg) < dss_pkg::PATTERN_STEPS) && (count_reg == 16'd0)
                    && cfg_reg.pattern_bits[6'd32 + (6'(step_reg) & 6'hF)];

    assign hdiff_pre = 17'(nb_reg) - 17'(hlp_reg);
    assign hlp_new   = hlp_reg + 16'(hdiff_pre >>> 2);
    assign hdiff     = 17'(nb_reg) - 17'(hlp_new);
    assign sat_src   = prod;

    // Advanced phases; the sine table looks them up in the same cycle they are stored
    assign kph_new = kph_reg + prod[31:0];
    assign sph_new = sph_reg + 32'd180 * 32'(cfg_reg.phase_per_hertz);

    // Feed the shared multiplier from the current state
    always_comb
    begin
        req = '0;
        rom_phase = kph_reg;
        unique case (state_reg)
            ST_KPH:
            begin
                req.a = 36'((32'd40 << 16) + 32'd80 * 32'(kenv_reg));
                req.b = 36'(cfg_reg.phase_per_hertz);
                req.shift = 6'd16;
            end
            ST_KSIN:
            begin
                rom_phase = kph_new;
            end
            ST_KM1:
            begin
                req.a = 36'(kenv_reg);
                req.b = 36'(sine);
                req.shift = 6'd16;
            end
            ST_KM2, ST_HM2:
            begin
                req.a = 36'(prod);
                req.b = (state_reg == ST_KM2) ? 36'd58982 : 36'd19661;
                req.shift = 6'd16;
            end
            ST_KDEC:
            begin
                req.a = 36'(kenv_reg);
                req.b = 36'(cfg_reg.kick_decay);
                req.shift = 6'd16;
            end
            ST_SSIN:
            begin
                rom_phase = sph_new;
            end
            ST_SM1:
            begin
                rom_phase = sph_reg;
                req.a = 36'(sine);
                req.b = 36'd19661;
                req.shift = 6'd16;
            end
            ST_SM2:
            begin
                req.a = 36'(senv_reg);
                req.b = 36'(inner_reg + 32'(prod));
                req.shift = 6'd16;
            end
            ST_SDEC:
            begin
                req.a = 36'(senv_reg);
                req.b = 36'(cfg_reg.snare_decay);
                req.shift = 6'd16;
            end
            ST_HM1:
            begin
                req.a = 36'(henv_reg);
                req.b = 36'(hdiff);
                req.shift = 6'd16;
            end
            ST_HDEC:
            begin
                req.a = 36'(henv_reg);
                req.b = 36'(cfg_reg.hat_decay);
                req.shift = 6'd16;
            end
            ST_MIX:
            begin
                req.a = 36'(mix_reg);
                req.b = 36'(cfg_reg.output_level);
                req.shift = 6'd16;
            end
            default:
            begin
                req = '0;
            end
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  state_next = (accept && tick_in.data[0]) ? ST_KPH : ST_IDLE;
            ST_KPH:   state_next = ST_KSIN;
            ST_KSIN:  state_next = ST_KM1;
            ST_KM1:   state_next = ST_KM2;
            ST_KM2:   state_next = ST_KDEC;
            ST_KDEC:  state_next = ST_SSIN;
            ST_SSIN:  state_next = ST_SM1;
            ST_SM1:   state_next = ST_SM2;
            ST_SM2:   state_next = ST_SDEC;
            ST_SDEC:  state_next = ST_HM1;
            ST_HM1:   state_next = ST_HM2;
            ST_HM2:   state_next = ST_HDEC;
            ST_HDEC:  state_next = ST_MIX;
            ST_MIX:   state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control and voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_bits     <= '0;
            cfg_reg.run_enable       <= 1'b1;
            cfg_reg.output_level     <= 16'd52429;
            cfg_reg.samples_per_step <= 16'd6000;
            cfg_reg.kick_decay       <= 16'd65524;
            cfg_reg.snare_decay      <= 16'd65511;
            cfg_reg.hat_decay        <= 16'd65440;
            cfg_reg.phase_per_hertz  <= 20'd89478;
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            kenv_reg      <= '0;
            senv_reg      <= '0;
            henv_reg      <= '0;
            kph_reg       <= '0;
            sph_reg       <= '0;
            hlp_reg       <= '0;
            lfsr_reg      <= 32'd1;
            out_valid_reg <= 1'b0;
            began_reg     <= 1'b0;
            kact_reg      <= 1'b0;
            sact_reg      <= 1'b0;
            hact_reg      <= 1'b0;
            mix_reg       <= '0;
            inner_reg     <= '0;
            na_reg        <= '0;
            nb_reg        <= '0;
            out_sample_reg <= '0;
            out_step_reg   <= '0;
            out_began_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    dss_pkg::REG_PATTERN: cfg_reg.pattern_bits     <= cfg.wdata;
                    dss_pkg::REG_RUN:     cfg_reg.run_enable       <= cfg.wdata[0];
                    dss_pkg::REG_LEVEL:   cfg_reg.output_level     <= cfg.wdata[15:0];
                    dss_pkg::REG_SPS:     cfg_reg.samples_per_step <= cfg.wdata[15:0];
                    dss_pkg::REG_KDECAY:  cfg_reg.kick_decay       <= cfg.wdata[15:0];
                    dss_pkg::REG_SDECAY:  cfg_reg.snare_decay      <= cfg.wdata[15:0];
                    dss_pkg::REG_HDECAY:  cfg_reg.hat_decay        <= cfg.wdata[15:0];
                    dss_pkg::REG_PPH:     cfg_reg.phase_per_hertz  <= cfg.wdata[19:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Start a sample: sequencer, triggers and noise
            if (accept)
            begin
                if (!tick_in.data[0])
                begin
                    // Tick low: emit silence, hold all state
                    out_valid_reg  <= 1'b1;
                    out_sample_reg <= '0;
                    out_step_reg   <= 4'(step_reg);
                    out_began_reg  <= 1'b0;
                end
                else
                begin
                    began_reg <= cfg_reg.run_enable && (count_reg == 16'd0);
                    if (cfg_reg.run_enable)
                    begin
                        if (trig_k) kph_reg <= '0;
                        if (trig_s) sph_reg <= '0;
                        if (cnt_inc >= len)
                        begin
                            count_reg <= '0;
                            step_reg  <= (int'(step_reg) == STEP_COUNT - 1) ? '0 : step_reg + 1'b1;
                        end
                        else
                        begin
                            count_reg <= cnt_inc;
                        end
                    end
                    kact_reg <= ((cfg_reg.run_enable && trig_k) ? dss_pkg::ENV_FULL : kenv_reg)
                                > dss_pkg::ENV_FLOOR;
                    sact_reg <= ((cfg_reg.run_enable && trig_s) ? dss_pkg::ENV_FULL : senv_reg)
                                > dss_pkg::ENV_FLOOR;
                    hact_reg <= ((cfg_reg.run_enable && trig_h) ? dss_pkg::ENV_FULL : henv_reg)
                                > dss_pkg::ENV_FLOOR;
                    if (cfg_reg.run_enable && trig_k) kenv_reg <= dss_pkg::ENV_FULL;
                    if (cfg_reg.run_enable && trig_s) senv_reg <= dss_pkg::ENV_FULL;
                    if (cfg_reg.run_enable && trig_h) henv_reg <= dss_pkg::ENV_FULL;
                    lfsr_reg  <= l2;
                    na_reg    <= l1[31:16];
                    nb_reg    <= l2[31:16];
                    mix_reg   <= '0;
                end
            end

            // Datapath updates per state
            unique case (state_reg)
                ST_KPH:  ;
                ST_KSIN:
                begin
                    if (kact_reg) kph_reg <= kph_new;
                end
                ST_KM2, ST_HM2: ;
                ST_KDEC:
                begin
                    // prod holds the kick term
                    if (kact_reg) mix_reg <= mix_reg + 32'(prod);
                end
                ST_SSIN:
                begin
                    if (kact_reg) kenv_reg <= prod[15:0];
                    if (sact_reg) sph_reg <= sph_new;
                end
                ST_SM1:
                begin
                    inner_reg <= 32'(na_reg >>> 1);
                end
                ST_SDEC:
                begin
                    if (sact_reg) mix_reg <= mix_reg + 32'(prod);
                end
                ST_HM1:
                begin
                    if (sact_reg) senv_reg <= prod[15:0];
                    if (hact_reg) hlp_reg <= hlp_new;
                end
                ST_HDEC:
                begin
                    if (hact_reg) mix_reg <= mix_reg + 32'(prod);
                end
                ST_MIX:
                begin
                    if (hact_reg) henv_reg <= prod[15:0];
                end
                ST_DONE:
                begin
                    out_valid_reg  <= 1'b1;
                    out_step_reg   <= 4'(step_reg);
                    out_began_reg  <= began_reg;
                    if (sat_src > 48'sd32767)
                        out_sample_reg <= 16'sh7FFF;
                    else if (sat_src < -48'sd32768)
                        out_sample_reg <= -16'sh8000;
                    else
                        out_sample_reg <= sat_src[15:0];
                end
                default: ;
            endcase
        end
    end

    // Checks
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !tick_in.ready)
        else $error("tick accepted while busy");
    a_done_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> out_valid_reg)
        else $error("finished sample not presented");
    a_started: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && tick_in.data[0]) |=> (state_reg == ST_KPH))
        else $error("sequence did not start");
endmodule
`default_nettype wire
